[design/cetp_pkg.sv]
`timescale 1ns / 1ps
package cetp_pkg;

    localparam int DEF_CHAN_COUNT = 16;
    localparam int DEF_COUNT_BITS = 16;

    localparam int KIND_W   = 3;
    localparam int CHAN_W   = 4;
    localparam int TIME_W   = 16;
    localparam int RKIND_W  = 2;
    localparam int STATUS_W = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK        = 3'd0,
        KIND_ALLOC       = 3'd1,
        KIND_FREE        = 3'd2,
        KIND_SCHED_NEW   = 3'd3,
        KIND_SCHED_BASED = 3'd4,
        KIND_FOLLOWUP    = 3'd5,
        KIND_DISABLE     = 3'd6,
        KIND_READ_TIME   = 3'd7
    } kind_t;

    typedef enum logic [RKIND_W-1:0] {
        RK_FIRED = 2'd0,
        RK_ACK   = 2'd1,
        RK_ALLOC = 2'd2,
        RK_TIME  = 2'd3
    } rkind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_NO_FREE    = 2'd1,
        ST_NOT_IN_USE = 2'd2
    } status_t;

    // Commands from the sequencer to the channel bank.
    typedef struct packed {
        logic wr_cmp;
        logic arm;
        logic disarm;
        logic scan;
    } bank_cmd_t;

endpackage

[design/cetp_req_if.sv]
`timescale 1ns / 1ps
interface cetp_req_if;
    import cetp_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [CHAN_W-1:0]   chan_id;
    logic [TIME_W-1:0]   delay_ticks;
    logic [TIME_W-1:0]   base_time;

    modport source (output valid, kind, chan_id, delay_ticks, base_time, input ready);
    modport sink   (input valid, kind, chan_id, delay_ticks, base_time, output ready);
endinterface

[design/cetp_rsp_if.sv]
`timescale 1ns / 1ps
interface cetp_rsp_if;
    import cetp_pkg::*;

    logic                valid;
    logic                ready;
    logic [RKIND_W-1:0]  result_kind;
    logic [CHAN_W-1:0]   out_channel;
    logic [STATUS_W-1:0] status;
    logic [TIME_W-1:0]   time_value;
    logic                last;

    modport source (output valid, result_kind, out_channel, status, time_value, last,
                    input ready);
    modport sink   (input valid, result_kind, out_channel, status, time_value, last,
                    output ready);
endinterface

[design/compare_event_timer_pool_unit.sv]
`timescale 1ns / 1ps
// Non-tick requests: accepted in idle, executed in the exec state once the result register is
// free, with the result registered; a new request is taken only once the previous one is done.
// Tick requests: the counter advances in the exec state, the compare scan then visits every
// channel through the shared comparator, then fired events are walked out in channel order.
// Asynchronous active-low reset clears the counter, compares, flags and restores the full
// free-channel stack; the block is ready in the first cycle after reset.
module compare_event_timer_pool_unit #(
    parameter int CHAN_COUNT = cetp_pkg::DEF_CHAN_COUNT,
    parameter int COUNT_BITS = cetp_pkg::DEF_COUNT_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    cetp_req_if.sink    req,
    cetp_rsp_if.source  rsp
);
    import cetp_pkg::*;

    localparam int IDX_W = (CHAN_COUNT > 1) ? $clog2(CHAN_COUNT) : 1;
    localparam int FC_W  = $clog2(CHAN_COUNT + 1);

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SCAN, S_EMIT} state_t;

    state_t                  state_reg, state_next;
    kind_t                   kind_reg, kind_next;
    logic [CHAN_W-1:0]       chan_reg, chan_next;
    logic [TIME_W-1:0]       delay_reg, delay_next;
    logic [TIME_W-1:0]       base_reg, base_next;
    logic                    oor_reg, oor_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [COUNT_BITS-1:0]   count_reg, count_next;
    logic [FC_W-1:0]         fc_reg, fc_next;
    logic [CHAN_COUNT-1:0]   fire_vec_reg, fire_vec_next;
    logic [IDX_W-1:0]        last_idx_reg, last_idx_next;
    logic                    any_fire_reg, any_fire_next;

    logic                    rsp_valid_reg, rsp_valid_next;
    rkind_t                  rk_reg, rk_next;
    logic [CHAN_W-1:0]       och_reg, och_next;
    status_t                 st_reg, st_next;
    logic [TIME_W-1:0]       tv_reg, tv_next;
    logic                    last_reg, last_next;

    logic [IDX_W-1:0]        stack_reg [CHAN_COUNT];
    logic [CHAN_COUNT-1:0]   alloc_reg;

    logic                    can_load;
    logic                    exec_go;
    logic [IDX_W-1:0]        top_idx;
    logic [IDX_W-1:0]        top_chan;
    logic                    push_en;
    logic                    pop_en;
    logic                    sched_op;
    logic [COUNT_BITS-1:0]   op_a;
    logic [COUNT_BITS-1:0]   op_b;
    logic [COUNT_BITS-1:0]   sum;
    logic [COUNT_BITS-1:0]   cmp_rd;
    logic                    fire;
    bank_cmd_t               bank_cmd;

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.result_kind = rk_reg;
    assign rsp.out_channel = och_reg;
    assign rsp.status      = st_reg;
    assign rsp.time_value  = tv_reg;
    assign rsp.last        = last_reg;

    assign can_load = !rsp_valid_reg || rsp.ready;
    assign exec_go  = (state_reg == S_EXEC) && ((kind_reg == KIND_TICK) || can_load);
    assign top_idx  = IDX_W'(fc_reg - FC_W'(1));
    assign top_chan = stack_reg[top_idx];
    assign sched_op = (kind_reg == KIND_SCHED_NEW) || (kind_reg == KIND_SCHED_BASED) ||
                      (kind_reg == KIND_FOLLOWUP);

    // Shared adder: counter increment and all compare-value sums.
    always_comb
    begin
        unique case (kind_reg)
            KIND_SCHED_BASED: op_a = COUNT_BITS'(base_reg);
            KIND_FOLLOWUP:    op_a = cmp_rd;
            default:          op_a = count_reg;
        endcase
        op_b = (kind_reg == KIND_TICK) ? COUNT_BITS'(1) : COUNT_BITS'(delay_reg);
        sum  = op_a + op_b;
    end

    always_comb
    begin
        bank_cmd.wr_cmp = exec_go && !oor_reg && sched_op;
        bank_cmd.arm    = exec_go && !oor_reg &&
                          ((kind_reg == KIND_SCHED_NEW) || (kind_reg == KIND_SCHED_BASED));
        bank_cmd.disarm = exec_go && !oor_reg && (kind_reg == KIND_DISABLE);
        bank_cmd.scan   = (state_reg == S_SCAN);
    end

    cetp_chan_bank #(
        .CHAN_COUNT (CHAN_COUNT),
        .COUNT_BITS (COUNT_BITS)
    ) u_bank (
        .clk     (clk),
        .rst_n   (rst_n),
        .idx     (idx_reg),
        .cmd     (bank_cmd),
        .wr_data (sum),
        .count   (count_reg),
        .rd_data (cmp_rd),
        .fire    (fire)
    );

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        chan_next      = chan_reg;
        delay_next     = delay_reg;
        base_next      = base_reg;
        oor_next       = oor_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        fc_next        = fc_reg;
        fire_vec_next  = fire_vec_reg;
        last_idx_next  = last_idx_reg;
        any_fire_next  = any_fire_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rk_next        = rk_reg;
        och_next       = och_reg;
        st_next        = st_reg;
        tv_next        = tv_reg;
        last_next      = last_reg;
        push_en        = 1'b0;
        pop_en         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next  = kind_t'(req.kind);
                    chan_next  = req.chan_id;
                    delay_next = req.delay_ticks;
                    base_next  = req.base_time;
                    oor_next   = (32'(req.chan_id) >= 32'(CHAN_COUNT));
                    idx_next   = IDX_W'(req.chan_id);
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (kind_reg == KIND_TICK)
                begin
                    count_next    = sum;
                    idx_next      = '0;
                    any_fire_next = 1'b0;
                    state_next    = S_SCAN;
                end
                else if (can_load)
                begin
                    rsp_valid_next = 1'b1;
                    last_next      = 1'b1;
                    tv_next        = '0;
                    och_next       = chan_reg;
                    st_next        = ST_OK;
                    rk_next        = RK_ACK;
                    state_next     = S_IDLE;
                    unique case (kind_reg)
                        KIND_ALLOC:
                        begin
                            rk_next = RK_ALLOC;
                            if (fc_reg == '0)
                            begin
                                och_next = '0;
                                st_next  = ST_NO_FREE;
                            end
                            else
                            begin
                                pop_en   = 1'b1;
                                fc_next  = fc_reg - FC_W'(1);
                                och_next = CHAN_W'(top_chan);
                            end
                        end
                        KIND_FREE:
                        begin
                            if (oor_reg || !alloc_reg[idx_reg] ||
                                (fc_reg == FC_W'(CHAN_COUNT)))
                            begin
                                st_next = ST_NOT_IN_USE;
                            end
                            else
                            begin
                                push_en = 1'b1;
                                fc_next = fc_reg + FC_W'(1);
                            end
                        end
                        KIND_READ_TIME:
                        begin
                            rk_next  = RK_TIME;
                            och_next = '0;
                            tv_next  = TIME_W'(count_reg);
                        end
                        default:
                        begin
                            if (oor_reg)
                            begin
                                st_next = ST_NOT_IN_USE;
                            end
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                fire_vec_next[idx_reg] = fire;
                if (fire)
                begin
                    last_idx_next = idx_reg;
                    any_fire_next = 1'b1;
                end
                if (idx_reg == IDX_W'(CHAN_COUNT - 1))
                begin
                    idx_next   = '0;
                    state_next = (any_fire_reg || fire) ? S_EMIT : S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_EMIT:
            begin
                if (!fire_vec_reg[idx_reg])
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
                else if (can_load)
                begin
                    rsp_valid_next = 1'b1;
                    rk_next        = RK_FIRED;
                    och_next       = CHAN_W'(idx_reg);
                    st_next        = ST_OK;
                    tv_next        = '0;
                    last_next      = (idx_reg == last_idx_reg);
                    if (idx_reg == last_idx_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            fc_reg        <= FC_W'(CHAN_COUNT);
            rsp_valid_reg <= 1'b0;
            any_fire_reg  <= 1'b0;
            fire_vec_reg  <= '0;
            last_idx_reg  <= '0;
            idx_reg       <= '0;
            kind_reg      <= KIND_TICK;
            oor_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            fc_reg        <= fc_next;
            rsp_valid_reg <= rsp_valid_next;
            any_fire_reg  <= any_fire_next;
            fire_vec_reg  <= fire_vec_next;
            last_idx_reg  <= last_idx_next;
            idx_reg       <= idx_next;
            kind_reg      <= kind_next;
            oor_reg       <= oor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chan_reg  <= chan_next;
        delay_reg <= delay_next;
        base_reg  <= base_next;
        rk_reg    <= rk_next;
        och_reg   <= och_next;
        st_reg    <= st_next;
        tv_reg    <= tv_next;
        last_reg  <= last_next;
    end

    // Free-channel stack and in-use bits; entry i starts out holding channel i.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHAN_COUNT; i++)
            begin
                stack_reg[i] <= IDX_W'(i);
            end
            alloc_reg <= '0;
        end
        else
        begin
            if (push_en)
            begin
                stack_reg[IDX_W'(fc_reg)] <= idx_reg;
                alloc_reg[idx_reg]        <= 1'b0;
            end
            if (pop_en)
            begin
                alloc_reg[top_chan] <= 1'b1;
            end
        end
    end

endmodule

[design/cetp_chan_bank.sv]
`timescale 1ns / 1ps
module cetp_chan_bank #(
    parameter int  CHAN_COUNT = cetp_pkg::DEF_CHAN_COUNT,
    parameter int  COUNT_BITS = cetp_pkg::DEF_COUNT_BITS,
    localparam int IDX_W      = (CHAN_COUNT > 1) ? $clog2(CHAN_COUNT) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [IDX_W-1:0]      idx,
    input  cetp_pkg::bank_cmd_t   cmd,
    input  logic [COUNT_BITS-1:0] wr_data,
    input  logic [COUNT_BITS-1:0] count,
    output logic [COUNT_BITS-1:0] rd_data,
    output logic                  fire
);
    import cetp_pkg::*;

    logic [COUNT_BITS-1:0] cmp_reg [CHAN_COUNT];
    logic [CHAN_COUNT-1:0] en_reg;
    logic [CHAN_COUNT-1:0] pend_reg;
    logic                  pend_new;

    // The single equality comparator is shared by all channels over the scan.
    assign rd_data  = cmp_reg[idx];
    assign pend_new = pend_reg[idx] | (cmp_reg[idx] == count);
    assign fire     = en_reg[idx] & pend_new;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHAN_COUNT; i++)
            begin
                cmp_reg[i] <= '0;
            end
            en_reg   <= '0;
            pend_reg <= '0;
        end
        else
        begin
            if (cmd.wr_cmp)
            begin
                cmp_reg[idx] <= wr_data;
            end
            if (cmd.arm)
            begin
                en_reg[idx]   <= 1'b1;
                pend_reg[idx] <= 1'b0;
            end
            else if (cmd.disarm)
            begin
                en_reg[idx] <= 1'b0;
            end
            else if (cmd.scan)
            begin
                pend_reg[idx] <= pend_new & ~fire;
            end
        end
    end

endmodule

[design/cetp_checker.sv]
`timescale 1ns / 1ps
module cetp_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [cetp_pkg::RKIND_W-1:0]  rsp_result_kind,
    input logic [cetp_pkg::CHAN_W-1:0]   rsp_out_channel,
    input logic [cetp_pkg::STATUS_W-1:0] rsp_status,
    input logic [cetp_pkg::TIME_W-1:0]   rsp_time_value,
    input logic                          rsp_last
);
    import cetp_pkg::*;

    // A held result keeps its kind, channel, status and last flag until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_result_kind) &&
            $stable(rsp_out_channel) && $stable(rsp_status) && $stable(rsp_last)))
        else $error("held result changed");

    // The sequencer works on one request at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request accepted while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_result_kind == RK_TIME) |->
            (rsp_last && rsp_out_channel == '0 && rsp_status == ST_OK))
        else $error("bad time read result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_result_kind == RK_FIRED) |->
            (rsp_status == ST_OK && rsp_time_value == '0))
        else $error("bad fired event result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_result_kind == RK_ALLOC && rsp_status == ST_NO_FREE) |->
            (rsp_out_channel == '0 && rsp_last))
        else $error("bad failed allocation result");

endmodule

bind compare_event_timer_pool_unit cetp_checker u_cetp_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_result_kind (rsp.result_kind),
    .rsp_out_channel (rsp.out_channel),
    .rsp_status      (rsp.status),
    .rsp_time_value  (rsp.time_value),
    .rsp_last        (rsp.last)
);

[bench/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
    import cetp_pkg::*;

    localparam int NCH           = DEF_CHAN_COUNT;
    localparam int IDLE_PCT      = 32;
    localparam int SETTLE_CYCLES = 80;

    typedef struct packed {
        rkind_t              rkind;
        logic [CHAN_W-1:0]   chan;
        status_t             status;
        logic [TIME_W-1:0]   tval;
        logic                last;
    } timer_result_t;

    logic clk    = 1'b0;
    logic rst_n  = 1'b0;
    logic steady = 1'b0;
    int   error_count = 0;

    cetp_req_if req_if ();
    cetp_rsp_if rsp_if ();

    compare_event_timer_pool_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // Shadow copy of the timer pool.
    logic [TIME_W-1:0]  count_now;
    logic [TIME_W-1:0]  cmp_val    [NCH];
    logic               armed      [NCH];
    logic               match_pend [NCH];
    logic               in_use     [NCH];
    logic [CHAN_W-1:0]  free_lifo  [NCH];
    int                 free_depth;
    timer_result_t      awaited_results [$];

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
        rsp_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);

    function automatic void predict_timer_step(kind_t k, logic [CHAN_W-1:0] ch,
                                               logic [TIME_W-1:0] dly,
                                               logic [TIME_W-1:0] base);
        timer_result_t batch [$];
        timer_result_t r;
        logic [CHAN_W-1:0] c;
        int i;
        r.rkind  = RK_ACK;
        r.chan   = ch;
        r.status = ST_OK;
        r.tval   = '0;
        r.last   = 1'b0;
        case (k)
            KIND_TICK:
            begin
                count_now = count_now + TIME_W'(1);
                // A match latches pending even on a disabled channel.
                for (i = 0; i < NCH; i++)
                    if (cmp_val[i] == count_now)
                        match_pend[i] = 1'b1;
                r.rkind = RK_FIRED;
                for (i = 0; i < NCH; i++)
                begin
                    if (armed[i] && match_pend[i])
                    begin
                        match_pend[i] = 1'b0;
                        r.chan = CHAN_W'(i);
                        batch.push_back(r);
                    end
                end
            end
            KIND_ALLOC:
            begin
                r.rkind = RK_ALLOC;
                if (free_depth == 0)
                begin
                    r.chan   = '0;
                    r.status = ST_NO_FREE;
                end
                else
                begin
                    free_depth--;
                    c = free_lifo[free_depth];
                    in_use[c] = 1'b1;
                    r.chan = c;
                end
                batch.push_back(r);
            end
            KIND_READ_TIME:
            begin
                r.rkind = RK_TIME;
                r.chan  = '0;
                r.tval  = count_now;
                batch.push_back(r);
            end
            KIND_FREE:
            begin
                if (!in_use[ch] || free_depth >= NCH)
                    r.status = ST_NOT_IN_USE;
                else
                begin
                    free_lifo[free_depth] = ch;
                    free_depth++;
                    in_use[ch] = 1'b0;
                end
                batch.push_back(r);
            end
            KIND_SCHED_NEW:
            begin
                cmp_val[ch]    = count_now + dly;
                match_pend[ch] = 1'b0;
                armed[ch]      = 1'b1;
                batch.push_back(r);
            end
            KIND_SCHED_BASED:
            begin
                cmp_val[ch]    = base + dly;
                match_pend[ch] = 1'b0;
                armed[ch]      = 1'b1;
                batch.push_back(r);
            end
            KIND_FOLLOWUP:
            begin
                cmp_val[ch] = cmp_val[ch] + dly;
                batch.push_back(r);
            end
            default:
            begin
                armed[ch] = 1'b0;
                batch.push_back(r);
            end
        endcase
        if (batch.size() > 0)
            batch[batch.size()-1].last = 1'b1;
        foreach (batch[n])
            awaited_results.push_back(batch[n]);
    endfunction

    task automatic send_request(kind_t k, logic [CHAN_W-1:0] ch,
                                logic [TIME_W-1:0] dly, logic [TIME_W-1:0] base);
        int gap;
        if (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            // Mostly short gaps, now and then a longer one.
            gap = ($urandom_range(7) == 0) ? $urandom_range(40, 8) : $urandom_range(3, 1);
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid       <= 1'b1;
        req_if.kind        <= k;
        req_if.chan_id     <= ch;
        req_if.delay_ticks <= dly;
        req_if.base_time   <= base;
        do
            @(posedge clk);
        while (req_if.ready !== 1'b1);
        predict_timer_step(k, ch, dly, base);
    endtask

    function automatic void check_field(string name, logic [TIME_W-1:0] want,
                                        logic [TIME_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        timer_result_t got;
        timer_result_t want;
        if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
        begin
            got = {rsp_if.result_kind, rsp_if.out_channel, rsp_if.status,
                   rsp_if.time_value, rsp_if.last};
            if (awaited_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual kind %0d chan %0d",
                         $time, rsp_if.result_kind, rsp_if.out_channel);
                $display("%0t:   status %0d time %0h last %0b", $time, rsp_if.status,
                         rsp_if.time_value, rsp_if.last);
                error_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                check_field("result_kind", TIME_W'(want.rkind), TIME_W'(got.rkind));
                check_field("out_channel", TIME_W'(want.chan), TIME_W'(got.chan));
                check_field("status", TIME_W'(want.status), TIME_W'(got.status));
                check_field("time_value", want.tval, got.tval);
                check_field("last", TIME_W'(want.last), TIME_W'(got.last));
            end
        end
    end

    // Counter reads zero after reset and a tick with nothing armed is silent.
    task automatic test_idle_counter();
        send_request(KIND_READ_TIME, CHAN_W'($urandom_range(15)),
                     TIME_W'($urandom_range(16'hFFFF)), TIME_W'($urandom_range(16'hFFFF)));
        send_request(KIND_TICK, 4'd15, 16'hFFFF, 16'hFFFF);
        send_request(KIND_READ_TIME, 4'd0, 16'h0000, 16'h0000);
    endtask

    task automatic test_alloc_free_basics();
        send_request(KIND_ALLOC, 4'd0, 16'h0000, 16'h0000);
        send_request(KIND_FREE, 4'd15, 16'h0000, 16'h0000);
        send_request(KIND_FREE, 4'd15, 16'h0000, 16'h0000);
        send_request(KIND_FREE, 4'd0, 16'h0000, 16'h0000);
        send_request(KIND_ALLOC, 4'd0, 16'hFFFF, 16'hFFFF);
    endtask

    // Several channels land on the same count through different schedule paths,
    // including wrapped sums, a disabled channel and a periodic followup.
    task automatic test_compare_paths();
        send_request(KIND_SCHED_NEW, 4'd0, 16'd2, 16'h0000);
        send_request(KIND_SCHED_BASED, 4'd15, 16'd4, 16'hFFFF);
        send_request(KIND_SCHED_NEW, 4'd7, 16'hFFFF, 16'h0000);
        send_request(KIND_FOLLOWUP, 4'd7, 16'd3, 16'h0000);
        send_request(KIND_SCHED_NEW, 4'd9, 16'd2, 16'h0000);
        send_request(KIND_DISABLE, 4'd9, 16'h0000, 16'h0000);
        send_request(KIND_TICK, 4'd0, 16'h0000, 16'h0000);
        send_request(KIND_TICK, 4'd0, 16'h0000, 16'h0000);
        send_request(KIND_READ_TIME, 4'd0, 16'h0000, 16'h0000);
        send_request(KIND_FOLLOWUP, 4'd0, 16'd1, 16'h0000);
        send_request(KIND_TICK, 4'd0, 16'h0000, 16'h0000);
        send_request(KIND_SCHED_BASED, 4'd5, 16'h7FFF, 16'h8000);
        send_request(KIND_DISABLE, 4'd5, 16'h0000, 16'h0000);
    endtask

    // Drain the pool with no idling on either side, ask once more, then hand
    // every channel back in random order.
    task automatic test_pool_exhaustion();
        logic [CHAN_W-1:0] order [NCH];
        logic [CHAN_W-1:0] tmp;
        int i;
        int j;
        steady = 1'b1;
        while (free_depth > 0)
            send_request(KIND_ALLOC, CHAN_W'($urandom_range(15)),
                         TIME_W'($urandom_range(16'hFFFF)), '0);
        send_request(KIND_ALLOC, CHAN_W'($urandom_range(15)), '0,
                     TIME_W'($urandom_range(16'hFFFF)));
        for (i = 0; i < NCH; i++)
            order[i] = CHAN_W'(i);
        for (i = NCH - 1; i > 0; i--)
        begin
            j = $urandom_range(i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (i = 0; i < NCH; i++)
            send_request(KIND_FREE, order[i], TIME_W'($urandom_range(16'hFFFF)), '0);
        steady = 1'b0;
    endtask

    // Every channel due on the same tick gives the longest burst of events.
    task automatic test_fire_all_channels();
        int d;
        int i;
        d = $urandom_range(3, 1);
        for (i = 0; i < NCH; i++)
            send_request(KIND_SCHED_NEW, CHAN_W'(i), TIME_W'(d),
                         TIME_W'($urandom_range(16'hFFFF)));
        for (i = 0; i < d; i++)
            send_request(KIND_TICK, CHAN_W'($urandom_range(15)), '0, '0);
    endtask

    task automatic test_random_traffic(int count);
        logic [CHAN_W-1:0] owned [$];
        logic [CHAN_W-1:0] ch;
        logic [TIME_W-1:0] dly;
        logic [TIME_W-1:0] base;
        int pick;
        int n;
        int i;
        for (n = 0; n < count; n++)
        begin
            owned.delete();
            for (i = 0; i < NCH; i++)
                if (in_use[i])
                    owned.push_back(CHAN_W'(i));
            if (owned.size() > 0 && $urandom_range(3) != 0)
                ch = owned[$urandom_range(owned.size() - 1)];
            else
                ch = CHAN_W'($urandom_range(15));
            // Mostly near-term deadlines so channels fire within the run.
            dly  = ($urandom_range(4) != 0) ? TIME_W'($urandom_range(6))
                                            : TIME_W'($urandom_range(16'hFFFF));
            base = TIME_W'($urandom_range(16'hFFFF));
            pick = $urandom_range(99);
            if (pick < 35)
                send_request(KIND_TICK, ch, dly, base);
            else if (pick < 47)
                send_request(KIND_ALLOC, ch, dly, base);
            else if (pick < 57)
                send_request(KIND_FREE, ch, dly, base);
            else if (pick < 72)
                send_request(KIND_SCHED_NEW, ch, dly, base);
            else if (pick < 80)
            begin
                if ($urandom_range(1) == 0)
                    dly = count_now + TIME_W'($urandom_range(5, 1)) - base;
                send_request(KIND_SCHED_BASED, ch, dly, base);
            end
            else if (pick < 88)
                send_request(KIND_FOLLOWUP, ch, dly, base);
            else if (pick < 94)
                send_request(KIND_DISABLE, ch, dly, base);
            else
                send_request(KIND_READ_TIME, ch, dly, base);
        end
    endtask

    initial
    begin
        req_if.valid       = 1'b0;
        req_if.kind        = KIND_TICK;
        req_if.chan_id     = '0;
        req_if.delay_ticks = '0;
        req_if.base_time   = '0;
        rsp_if.ready       = 1'b0;
        count_now  = '0;
        free_depth = NCH;
        for (int i = 0; i < NCH; i++)
        begin
            cmp_val[i]    = '0;
            armed[i]      = 1'b0;
            match_pend[i] = 1'b0;
            in_use[i]     = 1'b0;
            free_lifo[i]  = CHAN_W'(i);
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_idle_counter();
        test_alloc_free_basics();
        test_compare_paths();
        test_pool_exhaustion();
        test_fire_all_channels();
        test_random_traffic(90);
        req_if.valid <= 1'b0;

        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

[filelist.f]
design/cetp_pkg.sv
design/cetp_req_if.sv
design/cetp_rsp_if.sv
design/cetp_chan_bank.sv
design/compare_event_timer_pool_unit.sv
design/cetp_checker.sv
bench/tb_top.sv
